@@ rtl/bps_pkg.sv @@
package bps_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int AMP_BITS_DEF  = 16;

	localparam int CFG_IDX_W = 3;
	localparam int PHASE_W   = 3;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POS_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEG_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POS_AMP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NEG_AMP    = 3'd6;

	// phase codes
	localparam logic [PHASE_W-1:0] PH_BEFORE = 3'd0;
	localparam logic [PHASE_W-1:0] PH_POS    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_NEG    = 3'd2;
	localparam logic [PHASE_W-1:0] PH_GAP    = 3'd3;
	localparam logic [PHASE_W-1:0] PH_AFTER  = 3'd4;

	// control travelling alongside each word through the divider chain
	typedef struct packed {
		logic valid;
		logic after;
		logic early;
	} ctl_t;

endpackage

@@ rtl/bps_cell.sv @@
// One restoring-division step: brings in one dividend bit, subtracts the period if it fits.
module bps_cell #(
	parameter int TIME_BITS = bps_pkg::TIME_BITS_DEF,
	parameter int BIT_IDX   = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [TIME_BITS-1:0]  period,
	input  bps_pkg::ctl_t         ctl_in,
	input  logic [TIME_BITS-1:0]  t_in,
	input  logic [TIME_BITS-1:0]  rem_in,
	output bps_pkg::ctl_t         ctl_out,
	output logic [TIME_BITS-1:0]  t_out,
	output logic [TIME_BITS-1:0]  rem_out
);

	logic [TIME_BITS:0]   shifted;
	logic [TIME_BITS:0]   reduced;
	bps_pkg::ctl_t        ctl_q;
	logic [TIME_BITS-1:0] t_q;
	logic [TIME_BITS-1:0] rem_q;

	always_comb begin
		shifted = {rem_in, t_in[BIT_IDX]};
		// a zero period subtracts nothing, leaving the time stamp itself
		if (shifted >= {1'b0, period}) begin
			reduced = shifted - {1'b0, period};
		end else begin
			reduced = shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_q   <= t_in;
			rem_q <= reduced[TIME_BITS-1:0];
		end
	end

	assign ctl_out = ctl_q;
	assign t_out   = t_q;
	assign rem_out = rem_q;

endmodule

@@ rtl/bps_out.sv @@
// Phase decision and a two-word output queue.
module bps_out #(
	parameter int TIME_BITS = bps_pkg::TIME_BITS_DEF,
	parameter int AMP_BITS  = bps_pkg::AMP_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bps_pkg::ctl_t               ctl_in,
	input  logic [TIME_BITS-1:0]        pos_in,
	input  logic [TIME_BITS-1:0]        positive_width,
	input  logic [TIME_BITS-1:0]        negative_width,
	input  logic signed [AMP_BITS-1:0]  positive_amplitude,
	input  logic [AMP_BITS-2:0]         negative_amplitude,
	input  logic                        m_ready,
	output logic                        m_valid,
	output logic signed [AMP_BITS-1:0]  current,
	output logic [bps_pkg::PHASE_W-1:0] code,
	output logic                        en
);

	localparam int ENT_W = AMP_BITS + bps_pkg::PHASE_W;

	logic                        valid_s1;
	logic                        in_win_s1;
	logic [bps_pkg::PHASE_W-1:0] win_code_s1;
	logic                        lt_pw_s1;
	logic [TIME_BITS-1:0]        diff_s1;

	logic [ENT_W-1:0]            fifo_q [2];
	logic                        wr_ptr_q;
	logic                        rd_ptr_q;
	logic [1:0]                  count_q;

	logic [bps_pkg::PHASE_W-1:0] new_code;
	logic signed [AMP_BITS-1:0]  new_cur;
	logic                        push;
	logic                        pop;

	assign en   = (count_q != 2'd2);
	assign push = valid_s1 && en;
	assign pop  = m_valid && m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_win_s1   <= !(ctl_in.after || ctl_in.early);
			win_code_s1 <= ctl_in.after ? bps_pkg::PH_AFTER : bps_pkg::PH_BEFORE;
			lt_pw_s1    <= (pos_in < positive_width);
			diff_s1     <= pos_in - positive_width;
		end
	end

	always_comb begin
		new_code = win_code_s1;
		new_cur  = '0;
		if (in_win_s1) begin
			if (lt_pw_s1) begin
				new_code = bps_pkg::PH_POS;
				new_cur  = positive_amplitude;
			end else if (diff_s1 < negative_width) begin
				new_code = bps_pkg::PH_NEG;
				new_cur  = -$signed({1'b0, negative_amplitude});
			end else begin
				new_code = bps_pkg::PH_GAP;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= {new_code, new_cur};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign m_valid = (count_q != 2'd0);
	assign current = fifo_q[rd_ptr_q][AMP_BITS-1:0];
	assign code    = fifo_q[rd_ptr_q][ENT_W-1:AMP_BITS];

endmodule

@@ rtl/biphasic_pulse_stimulus.sv @@
// Biphasic pulse stimulus generator.
// s_axis carries one time stamp per word (tdata: time_now). m_axis returns one
// word per time stamp (tdata: drive_current, then phase_code above it), in order.
// Inside [start_time, stop_time] the cycle position is time_now mod period;
// positions below positive_width drive positive_amplitude, the next
// negative_width positions drive -negative_amplitude, the rest drive zero.
// Outside the window the current is zero (phase code before/after).
// The remainder comes from a row of TIME_BITS division cells, one dividend bit
// each; every cell registers its step before the phase decision is registered.
// One word per cycle is accepted and delivered when the receiver keeps up.
// A two-word output queue sits after the chain: s_axis_tready stays high while
// one result waits, and drops only when both queue entries are full, freezing
// the whole chain until m_axis_tready takes a word.
// Reset empties the chain and queue and loads the register defaults (period 1,
// everything else 0). The user must write registers through cfg_we/cfg_index/cfg_wdata
// only while no word is in flight (unenforced); indexes past the last register are ignored.
module biphasic_pulse_stimulus #(
	parameter int TIME_BITS = bps_pkg::TIME_BITS_DEF,
	parameter int AMP_BITS  = bps_pkg::AMP_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bps_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [((TIME_BITS > AMP_BITS) ? TIME_BITS : AMP_BITS)-1:0] cfg_wdata,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,   // [0 +: TIME_BITS] time_now
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [0 +: AMP_BITS] drive_current, [AMP_BITS +: 3] phase_code
	output logic [((AMP_BITS + bps_pkg::PHASE_W + 7) / 8) * 8 - 1:0] m_axis_tdata
);

	localparam int OUT_W = ((AMP_BITS + bps_pkg::PHASE_W + 7) / 8) * 8;

	logic [TIME_BITS-1:0]        start_time_q;
	logic [TIME_BITS-1:0]        stop_time_q;
	logic [TIME_BITS-1:0]        period_q;
	logic [TIME_BITS-1:0]        pos_width_q;
	logic [TIME_BITS-1:0]        neg_width_q;
	logic signed [AMP_BITS-1:0]  pos_amp_q;
	logic [AMP_BITS-2:0]         neg_amp_q;

	logic                        en;
	logic [TIME_BITS-1:0]        time_now;
	bps_pkg::ctl_t               ctl_c [TIME_BITS+1];
	logic [TIME_BITS-1:0]        t_c   [TIME_BITS+1];
	logic [TIME_BITS-1:0]        rem_c [TIME_BITS+1];

	logic signed [AMP_BITS-1:0]  drive_current;
	logic [bps_pkg::PHASE_W-1:0] phase_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
			stop_time_q  <= '0;
			period_q     <= TIME_BITS'(1);
			pos_width_q  <= '0;
			neg_width_q  <= '0;
			pos_amp_q    <= '0;
			neg_amp_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bps_pkg::REG_START_TIME: start_time_q <= cfg_wdata[TIME_BITS-1:0];
				bps_pkg::REG_STOP_TIME:  stop_time_q  <= cfg_wdata[TIME_BITS-1:0];
				bps_pkg::REG_PERIOD:     period_q     <= cfg_wdata[TIME_BITS-1:0];
				bps_pkg::REG_POS_WIDTH:  pos_width_q  <= cfg_wdata[TIME_BITS-1:0];
				bps_pkg::REG_NEG_WIDTH:  neg_width_q  <= cfg_wdata[TIME_BITS-1:0];
				bps_pkg::REG_POS_AMP:    pos_amp_q    <= cfg_wdata[AMP_BITS-1:0];
				bps_pkg::REG_NEG_AMP:    neg_amp_q    <= cfg_wdata[AMP_BITS-2:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = en;
	assign time_now      = s_axis_tdata[TIME_BITS-1:0];

	// window test up front; after-stop wins when the window is empty
	always_comb begin
		ctl_c[0].valid = s_axis_tvalid && en;
		ctl_c[0].after = (time_now > stop_time_q);
		ctl_c[0].early = (time_now <= stop_time_q) && (time_now < start_time_q);
		t_c[0]         = time_now;
		rem_c[0]       = '0;
	end

	for (genvar i = 0; i < TIME_BITS; i++) begin : g_cell
		bps_cell #(
			.TIME_BITS(TIME_BITS),
			.BIT_IDX  (TIME_BITS - 1 - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.period (period_q),
			.ctl_in (ctl_c[i]),
			.t_in   (t_c[i]),
			.rem_in (rem_c[i]),
			.ctl_out(ctl_c[i+1]),
			.t_out  (t_c[i+1]),
			.rem_out(rem_c[i+1])
		);
	end

	bps_out #(
		.TIME_BITS(TIME_BITS),
		.AMP_BITS (AMP_BITS)
	) u_out (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl_in            (ctl_c[TIME_BITS]),
		.pos_in            (rem_c[TIME_BITS]),
		.positive_width    (pos_width_q),
		.negative_width    (neg_width_q),
		.positive_amplitude(pos_amp_q),
		.negative_amplitude(neg_amp_q),
		.m_ready           (m_axis_tready),
		.m_valid           (m_axis_tvalid),
		.current           (drive_current),
		.code              (phase_code),
		.en                (en)
	);

	assign m_axis_tdata = OUT_W'({phase_code, drive_current});

endmodule

@@ rtl/bps_checker.sv @@
module bps_checker #(
	parameter int TIME_BITS = bps_pkg::TIME_BITS_DEF,
	parameter int AMP_BITS  = bps_pkg::AMP_BITS_DEF
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  m_axis_tvalid,
	input logic                                  m_axis_tready,
	input logic [((AMP_BITS + bps_pkg::PHASE_W + 7) / 8) * 8 - 1:0] m_axis_tdata
);

	localparam int OUT_W = ((AMP_BITS + bps_pkg::PHASE_W + 7) / 8) * 8;

	logic [bps_pkg::PHASE_W-1:0] code;
	logic [AMP_BITS-1:0]         cur;
	logic [OUT_W-1:0]            pad_mask;

	assign code     = m_axis_tdata[AMP_BITS +: bps_pkg::PHASE_W];
	assign cur      = m_axis_tdata[AMP_BITS-1:0];
	assign pad_mask = ~(OUT_W'({(AMP_BITS + bps_pkg::PHASE_W){1'b1}}));

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> code <= bps_pkg::PH_AFTER)
		else $error("phase code out of range");

	// outside the active phases the drive is off
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (code == bps_pkg::PH_BEFORE || code == bps_pkg::PH_GAP ||
			code == bps_pkg::PH_AFTER) |-> cur == '0)
		else $error("current not zero outside pulse phases");

	// negative phase never drives a positive current
	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && code == bps_pkg::PH_NEG |-> cur[AMP_BITS-1] || cur == '0)
		else $error("negative phase with positive current");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata & pad_mask) == '0)
		else $error("padding bits set");

endmodule

bind biphasic_pulse_stimulus bps_checker #(
	.TIME_BITS(TIME_BITS),
	.AMP_BITS (AMP_BITS)
) u_bps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

@@ verif/bps_checker.sv @@
`timescale 1ns / 1ps

module bps_scoreboard #(
	parameter int TIME_BITS = bps_pkg::TIME_BITS_DEF,
	parameter int AMP_BITS  = bps_pkg::AMP_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bps_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [((TIME_BITS > AMP_BITS) ? TIME_BITS : AMP_BITS)-1:0] cfg_wdata,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	input  logic [((TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // [0 +: TIME_BITS] time_now
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [0 +: AMP_BITS] drive_current, [AMP_BITS +: 3] phase_code
	input  logic [((AMP_BITS + bps_pkg::PHASE_W + 7) / 8) * 8 - 1:0] m_tdata,
	output int                                    errors,
	output int                                    pending
);

	typedef struct packed {
		logic signed [AMP_BITS-1:0]  current;
		logic [bps_pkg::PHASE_W-1:0] phase;
	} pulse_t;

	// shadow copy of the register file
	logic [TIME_BITS-1:0] win_start, win_stop, cyc_len, pos_width, neg_width;
	logic [AMP_BITS-1:0]  pos_amp;
	logic [AMP_BITS-2:0]  neg_mag;

	pulse_t due_pulses[$];
	int     n_err = 0;

	assign errors = n_err;

	function automatic pulse_t pulse_at(logic [TIME_BITS-1:0] t);
		logic [TIME_BITS-1:0] offs;
		pulse_t p;
		p.current = '0;
		// after-stop test first, so it wins when start lies past stop
		if (t > win_stop) begin
			p.phase = bps_pkg::PH_AFTER;
		end else if (t < win_start) begin
			p.phase = bps_pkg::PH_BEFORE;
		end else begin
			// zero period: no wrap
			offs = (cyc_len != 0) ? t % cyc_len : t;
			if (offs < pos_width) begin
				p.current = pos_amp;
				p.phase   = bps_pkg::PH_POS;
			end else if (offs - pos_width < neg_width) begin
				p.current = -{1'b0, neg_mag};
				p.phase   = bps_pkg::PH_NEG;
			end else begin
				p.phase = bps_pkg::PH_GAP;
			end
		end
		return p;
	endfunction

	task automatic flag(string msg);
		n_err++;
		if (n_err <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pulse_t got, want;
		if (!arst_n) begin
			win_start <= '0;
			win_stop  <= '0;
			cyc_len   <= TIME_BITS'(1);
			pos_width <= '0;
			neg_width <= '0;
			pos_amp   <= '0;
			neg_mag   <= '0;
			due_pulses.delete();
			pending   <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bps_pkg::REG_START_TIME: win_start <= cfg_wdata[TIME_BITS-1:0];
					bps_pkg::REG_STOP_TIME:  win_stop  <= cfg_wdata[TIME_BITS-1:0];
					bps_pkg::REG_PERIOD:     cyc_len   <= cfg_wdata[TIME_BITS-1:0];
					bps_pkg::REG_POS_WIDTH:  pos_width <= cfg_wdata[TIME_BITS-1:0];
					bps_pkg::REG_NEG_WIDTH:  neg_width <= cfg_wdata[TIME_BITS-1:0];
					bps_pkg::REG_POS_AMP:    pos_amp   <= cfg_wdata[AMP_BITS-1:0];
					bps_pkg::REG_NEG_AMP:    neg_mag   <= cfg_wdata[AMP_BITS-2:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				due_pulses = {due_pulses, pulse_at(s_tdata[TIME_BITS-1:0])};
			if (m_tvalid && m_tready) begin
				got.current = m_tdata[0 +: AMP_BITS];
				got.phase   = m_tdata[AMP_BITS +: bps_pkg::PHASE_W];
				if (due_pulses.size() == 0) begin
					flag($sformatf("unexpected word: drive_current %0d phase_code %0d",
						got.current, got.phase));
				end else begin
					want = due_pulses.pop_front();
					if (got.current !== want.current)
						flag($sformatf("drive_current expected %0d, got %0d",
							want.current, got.current));
					if (got.phase !== want.phase)
						flag($sformatf("phase_code expected %0d, got %0d",
							want.phase, got.phase));
				end
			end
			pending <= due_pulses.size();
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int TIME_BITS = bps_pkg::TIME_BITS_DEF;
	localparam int AMP_BITS  = bps_pkg::AMP_BITS_DEF;
	localparam int CFG_W     = (TIME_BITS > AMP_BITS) ? TIME_BITS : AMP_BITS;
	localparam int S_W       = ((TIME_BITS + 7) / 8) * 8;
	localparam int M_W       = ((AMP_BITS + bps_pkg::PHASE_W + 7) / 8) * 8;
	// past the end of the register map, writes must be dropped
	localparam logic [bps_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [bps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]              cfg_wdata = '0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [S_W-1:0]                s_axis_tdata = '0;   // [0 +: TIME_BITS] time_now
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	// [0 +: AMP_BITS] drive_current, [AMP_BITS +: 3] phase_code
	logic [M_W-1:0]                m_axis_tdata;

	int errors, pending;
	int sent = 0;

	logic [CFG_W-1:0]     setting[bps_pkg::REG_START_TIME:bps_pkg::REG_NEG_AMP];
	logic [TIME_BITS-1:0] stamps[$];

	bit src_quiet = 1'b0, sink_quiet = 1'b0;
	int src_run = 0, sink_run = 0;

	always #1 clk = ~clk;

	biphasic_pulse_stimulus dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	bps_scoreboard chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_tdata   (s_axis_tdata),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic choose(logic [CFG_W-1:0] s, logic [CFG_W-1:0] e, logic [CFG_W-1:0] p,
			logic [CFG_W-1:0] pw, logic [CFG_W-1:0] nw,
			logic [CFG_W-1:0] pa, logic [CFG_W-1:0] na);
		setting[bps_pkg::REG_START_TIME] = s;
		setting[bps_pkg::REG_STOP_TIME]  = e;
		setting[bps_pkg::REG_PERIOD]     = p;
		setting[bps_pkg::REG_POS_WIDTH]  = pw;
		setting[bps_pkg::REG_NEG_WIDTH]  = nw;
		setting[bps_pkg::REG_POS_AMP]    = pa;
		setting[bps_pkg::REG_NEG_AMP]    = na;
	endtask

	task automatic add_stamp(logic [TIME_BITS-1:0] t);
		stamps = {stamps, t};
	endtask

	// called with the block idle; cfg_we dropped once at the end
	task automatic program_regs(bit poke_unused);
		for (int i = bps_pkg::REG_START_TIME; i <= bps_pkg::REG_NEG_AMP; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[bps_pkg::CFG_IDX_W-1:0];
			cfg_wdata <= setting[i];
			@(posedge clk);
		end
		if (poke_unused) begin
			cfg_index <= REG_NONE;
			cfg_wdata <= $urandom;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_time(logic [TIME_BITS-1:0] t);
		int gap;
		if (src_run == 0) begin
			src_run   = $urandom_range(10, 60);
			src_quiet = ($urandom_range(0, 3) == 0);
		end
		src_run--;
		gap = src_quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= S_W'(t);
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	// every time stamp yields a word, so an empty scoreboard means idle
	task automatic play();
		foreach (stamps[k])
			send_time(stamps[k]);
		stamps.delete();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_phase();
		int kind, win, n;
		logic [TIME_BITS-1:0] p, s, e, pw, nw;
		logic [CFG_W-1:0] pa, na;
		kind = $urandom_range(0, 9);
		if (kind < 6)
			p = $urandom_range(1, 40);
		else if (kind == 6)
			p = '0;
		else if (kind == 7)
			p = '1;
		else
			p = $urandom;
		if (p != 0 && p <= 40) begin
			pw = $urandom_range(0, p);
			nw = $urandom_range(0, p);
		end else begin
			pw = (kind[0]) ? $urandom : (p >> $urandom_range(1, 4));
			nw = (kind[1]) ? $urandom : (p >> $urandom_range(1, 4));
			if (kind == 6) begin
				pw = $urandom_range(0, 200);
				nw = $urandom_range(0, 200);
			end
		end
		if ($urandom_range(0, 4) == 0)
			nw = '0;   // monophasic
		case ($urandom_range(0, 4))
			0: begin
				s = '0;
				e = '1;
			end
			1: begin
				s = $urandom;
				e = s + $urandom_range(0, 400);
				if (e < s)
					e = '1;
			end
			2: begin
				s = $urandom_range(100, 1000);
				e = s - $urandom_range(1, 50);
			end
			3: begin
				s = '1 - $urandom_range(0, 300);
				e = '1;
			end
			default: begin
				s = $urandom_range(0, 50);
				e = s + $urandom_range(0, 400);
			end
		endcase
		pa = $urandom;
		na = $urandom;
		case ($urandom_range(0, 3))
			0: pa[AMP_BITS-1:0] = {1'b0, {(AMP_BITS - 1){1'b1}}};
			1: pa[AMP_BITS-1:0] = {1'b1, {(AMP_BITS - 1){1'b0}}};
			default: ;
		endcase
		case ($urandom_range(0, 3))
			0: na[AMP_BITS-2:0] = '1;
			1: na[AMP_BITS-2:0] = '0;
			default: ;
		endcase
		choose(s, e, p, pw, nw, pa, na);
		program_regs($urandom_range(0, 4) == 0);
		win = (e >= s && e - s < 1000) ? int'(e - s) : 400;
		n = $urandom_range(20, 60);
		repeat (n) begin
			if ($urandom_range(0, 6) == 0)
				add_stamp($urandom);
			else
				add_stamp(s - 8 + $urandom_range(0, win + 16));
		end
		play();
	endtask

	// receiver: random stall before each word, with runs of no stalling
	initial begin : sink
		int n;
		wait (arst_n);
		forever begin
			if (sink_run == 0) begin
				sink_run   = $urandom_range(10, 60);
				sink_quiet = ($urandom_range(0, 3) == 0);
			end
			sink_run--;
			n = sink_quiet ? 0 : $urandom_range(0, 18);
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: period 1, window holding only tick 0
		stamps = '{32'd0, 32'd1, 32'hFFFF_FFFF};
		play();

		// plain biphasic cycle, largest magnitudes
		choose(10, 100, 8, 3, 2, 32'h7FFF, 32'h7FFF);
		program_regs(1'b0);
		stamps = '{32'd9, 32'd10, 32'd11, 32'd12, 32'd13, 32'd16, 32'd100, 32'd101};
		play();

		// start past stop
		choose(50, 20, 8, 3, 2, 32'h1234, 32'h0100);
		program_regs(1'b0);
		stamps = '{32'd10, 32'd30, 32'd60};
		play();

		// zero period, most negative positive amplitude, zero magnitude
		choose(0, 32'hFFFF_FFFF, 0, 5, 5, 32'h8000, 0);
		program_regs(1'b0);
		stamps = '{32'd3, 32'd7, 32'd12, 32'hFFFF_FFFF};
		play();

		// widths whose sum would wrap; junk above the amplitude fields
		choose(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
			32'hABCD_0001, 32'hFFFF_FFFF);
		program_regs(1'b1);
		stamps = '{32'd5, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
		play();

		while (sent < 660)
			random_phase();

		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
